>>> design/pfe_pkg.sv
// Shared types, codes and helpers for the protobuf field header encoder.
// No dependencies; imported by every module of the block.
package pfe_pkg;

  // Longest encoding of one field: 5 tag bytes plus 10 payload bytes
  localparam int MaxBytes    = 15;
  localparam int VarintBytes = 10;
  localparam int TagBytes    = 5;
  localparam int CntW        = $clog2(MaxBytes + 1);

  typedef logic [7:0] byte_t;

  typedef enum logic [3:0] {
    OpSint32 = 4'd0,
    OpInt32  = 4'd1,
    OpUint32 = 4'd2,
    OpSint64 = 4'd3,
    OpUint64 = 4'd4,
    OpFixed32 = 4'd5,
    OpFixed64 = 4'd6,
    OpBool   = 4'd7,
    OpLength = 4'd8
  } pfe_op_e;

  typedef enum logic [2:0] {
    WtVarint  = 3'd0,
    WtFixed64 = 3'd1,
    WtLength  = 3'd2,
    WtFixed32 = 3'd5
  } pfe_wt_e;

  // Encoded request handed from the encoder to the serializer
  typedef struct packed {
    logic                        ok;
    logic [CntW-1:0]             count;
    logic [MaxBytes-1:0][7:0]    data;
  } pfe_enc_t;

  // Number of 7-bit groups a varint of v needs (at least one)
  function automatic logic [3:0] varint_len(logic [63:0] v);
    logic [3:0] len;
    len = 4'd1;
    for (int i = 1; i < VarintBytes; i++) begin
      if ((v >> (7 * i)) != 64'd0) len = 4'(i + 1);
    end
    return len;
  endfunction

  // Byte k of a varint of v whose length is len
  function automatic byte_t varint_byte(logic [63:0] v, logic [3:0] k, logic [3:0] len);
    logic [69:0] vx;
    logic [6:0]  grp;
    vx  = {6'd0, v};
    grp = vx[7 * k +: 7];
    return {(k + 4'd1) < len, grp};
  endfunction

endpackage

>>> design/pfe_encode.sv
// Field encoder: builds all wire bytes of one field and their count.
// Depends on pfe_pkg (opcodes, wire types, varint helpers).
module pfe_encode import pfe_pkg::*; (
  input  logic [31:0] field_number_i,
  input  logic [3:0]  opcode_i,
  input  logic [63:0] payload_value_i,
  output pfe_enc_t    enc_o
);

  logic [31:0] lo32;
  logic [2:0]  wt;
  logic [63:0] tag_val;
  logic [3:0]  tag_len;
  logic [63:0] var_val;
  logic        is_fixed;
  logic [3:0]  pay_len;
  logic        ok;
  byte_t       tag_b [MaxBytes];
  byte_t       pay_b [MaxBytes];

  assign lo32 = payload_value_i[31:0];

  // Wire type and value to encode, by opcode
  always_comb begin
    wt       = WtVarint;
    var_val  = payload_value_i;
    is_fixed = 1'b0;
    ok       = 1'b1;
    unique case (opcode_i)
      OpSint32:  var_val = {32'd0, {lo32[30:0], 1'b0} ^ {32{lo32[31]}}};
      OpInt32:   var_val = {{32{lo32[31]}}, lo32};
      OpUint32:  var_val = {32'd0, lo32};
      OpSint64:  var_val = {payload_value_i[62:0], 1'b0} ^ {64{payload_value_i[63]}};
      OpUint64:  var_val = payload_value_i;
      OpFixed32: begin
        wt       = WtFixed32;
        is_fixed = 1'b1;
      end
      OpFixed64: begin
        wt       = WtFixed64;
        is_fixed = 1'b1;
      end
      OpBool:    is_fixed = 1'b1;
      OpLength: begin
        wt      = WtLength;
        var_val = {32'd0, lo32};
      end
      default:   ok = 1'b0;
    endcase
  end

  assign tag_val = {29'd0, field_number_i, wt};
  assign tag_len = varint_len(tag_val);

  // Tag bytes, payload bytes and payload length
  always_comb begin
    for (int k = 0; k < MaxBytes; k++) begin
      tag_b[k] = (k < TagBytes) ? varint_byte(tag_val, 4'(k), tag_len) : 8'd0;
      pay_b[k] = 8'd0;
    end
    if (is_fixed) begin
      unique case (opcode_i)
        OpFixed32: pay_len = 4'd4;
        OpFixed64: pay_len = 4'd8;
        default:   pay_len = 4'd1;
      endcase
      if (opcode_i == OpBool) begin
        pay_b[0] = {7'd0, payload_value_i != 64'd0};
      end else begin
        for (int k = 0; k < 8; k++) pay_b[k] = payload_value_i[8 * k +: 8];
        if (opcode_i == OpFixed32) begin
          for (int k = 4; k < 8; k++) pay_b[k] = 8'd0;
        end
      end
    end else begin
      pay_len = varint_len(var_val);
      for (int k = 0; k < VarintBytes; k++) pay_b[k] = varint_byte(var_val, 4'(k), pay_len);
    end
  end

  // Splice payload behind the tag
  always_comb begin
    logic [3:0] j;
    j = 4'd0;
    enc_o.ok    = ok;
    enc_o.count = CntW'(tag_len + pay_len);
    for (int i = 0; i < MaxBytes; i++) begin
      j = 4'(i) - tag_len;
      enc_o.data[i] = (4'(i) < tag_len) ? tag_b[4'(i)] : pay_b[j];
    end
  end

endmodule

>>> design/pfe_serializer.sv
// Byte serializer: holds one encoded field and shifts out one byte per cycle.
// Depends on pfe_pkg (pfe_enc_t, sizes).
module pfe_serializer import pfe_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  pfe_enc_t        enc_i,
  output logic            busy_o,
  output logic            valid_o,
  output logic [7:0]      out_byte_o,
  output logic            last_byte_o,
  output logic [3:0]      total_bytes_o
);

  logic [MaxBytes-1:0][7:0] buf_q, buf_d;
  logic [CntW-1:0]          cnt_q, cnt_d;
  logic [CntW-1:0]          total_q, total_d;

  // Load a new field or shift the current one by a byte
  always_comb begin
    buf_d   = buf_q;
    cnt_d   = cnt_q;
    total_d = total_q;
    if (load_i && enc_i.ok) begin
      buf_d   = enc_i.data;
      cnt_d   = enc_i.count;
      total_d = enc_i.count;
    end else if (cnt_q != '0) begin
      buf_d   = {8'd0, buf_q[MaxBytes-1:1]};
      cnt_d   = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q   <= buf_d;
    total_q <= total_d;
  end

  // Free for a new request once the last byte is on the outputs
  assign busy_o        = cnt_q > CntW'(1);
  assign valid_o       = cnt_q != '0;
  assign out_byte_o    = buf_q[0];
  assign last_byte_o   = cnt_q == CntW'(1);
  assign total_bytes_o = 4'(total_q);

  a_busy_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> valid_o) else $error("busy without a byte on the outputs");
  a_busy_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> valid_o && cnt_q == $past(cnt_q) - 1'b1)
    else $error("byte count did not step down");
  a_total_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> $stable(total_bytes_o)) else $error("total changed within a field");
  a_last_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_byte_o |-> valid_o) else $error("last marker without a byte");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> cnt_q <= total_q) else $error("remaining count above total");

endmodule

>>> design/protobuf_field_header_encoder.sv
// Protobuf field header encoder: tag varint plus payload header bytes.
// The first byte is on the outputs in the cycle after the request is taken.
// Output: one byte per cycle, 2..15 bytes per field; a new request is taken
// during the last byte.
// Reset: rst_ni (async, active low) drops any field in flight; receiver cannot stall.
// Depends on pfe_pkg, pfe_encode, pfe_serializer.
module protobuf_field_header_encoder import pfe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] field_number_i,
  input  logic [3:0]  opcode_i,
  input  logic [63:0] payload_value_i,
  output logic        result_valid_o,
  output logic [7:0]  out_byte_o,
  output logic        last_byte_o,
  output logic [3:0]  total_bytes_o
);

  pfe_enc_t enc;
  logic     accept;

  assign accept = start && !busy;

  // Build the whole encoding straight from the request
  pfe_encode u_encode (
    .field_number_i  (field_number_i),
    .opcode_i        (opcode_i),
    .payload_value_i (payload_value_i),
    .enc_o           (enc)
  );

  // Hold it and stream it out
  pfe_serializer u_serializer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (accept),
    .enc_i         (enc),
    .busy_o        (busy),
    .valid_o       (result_valid_o),
    .out_byte_o    (out_byte_o),
    .last_byte_o   (last_byte_o),
    .total_bytes_o (total_bytes_o)
  );

endmodule
